FILE: design/quaternion_to_rotation_matrix_top_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros for the quaternion to rotation matrix block
// Concurrent checks, compiled out when SYNTH is defined.
// ---------------------------------------------------------------------------
`ifndef QUATERNION_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`define QUATERNION_TO_ROTATION_MATRIX_TOP_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication
`define QTRM_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("same-cycle check failed");
// Next-cycle implication
`define QTRM_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");
`else
`define QTRM_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define QTRM_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: design/qtrm_pkg.sv
// ---------------------------------------------------------------------------
// qtrm_pkg
// Shared types and lane numbering for the quaternion to rotation matrix block.
// ---------------------------------------------------------------------------
package qtrm_pkg;

  localparam int NUM_LANES = 9;

  // Matrix entry per lane, row major
  localparam int LANE_M00 = 0;
  localparam int LANE_M01 = 1;
  localparam int LANE_M02 = 2;
  localparam int LANE_M10 = 3;
  localparam int LANE_M11 = 4;
  localparam int LANE_M12 = 5;
  localparam int LANE_M20 = 6;
  localparam int LANE_M21 = 7;
  localparam int LANE_M22 = 8;

  // Per-stage control travelling with the data
  typedef struct packed {
    logic valid;
    logic degen;
  } ctl_t;

endpackage

FILE: design/qtrm_front.sv
// ---------------------------------------------------------------------------
// qtrm_front
// Two stages: products and squares, then squared length and entry numerators.
// ---------------------------------------------------------------------------
module qtrm_front #(
  parameter int W = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         in_valid_i,
  output logic                                         in_ready_o,
  input  logic signed [W-1:0]                          w_i,
  input  logic signed [W-1:0]                          x_i,
  input  logic signed [W-1:0]                          y_i,
  input  logic signed [W-1:0]                          z_i,
  input  logic                                         out_ready_i,
  output qtrm_pkg::ctl_t                               out_ctl_o,
  output logic [2*W:0]                                 out_n_o,
  output logic [qtrm_pkg::NUM_LANES-1:0][2*W:0]        out_a_o,
  output logic [qtrm_pkg::NUM_LANES-1:0]               out_neg_o
);
  localparam int PW = 2 * W;
  localparam int NW = 2 * W + 1;

  // Stage A registers
  qtrm_pkg::ctl_t          ctl_a_q;
  logic [PW-2:0]           ww_q, xx_q, yy_q, zz_q;
  logic signed [PW-1:0]    xy_q, wz_q, xz_q, wy_q, yz_q, wx_q;
  logic                    rdy_a;

  // Stage B registers
  qtrm_pkg::ctl_t                        ctl_b_q;
  logic [NW-1:0]                         n_q;
  logic [qtrm_pkg::NUM_LANES-1:0][NW-1:0] a_q, a_d;
  logic [qtrm_pkg::NUM_LANES-1:0]        neg_q, neg_d;
  logic [NW-1:0]                         n_d;

  logic signed [PW-1:0] sq_w, sq_x, sq_y, sq_z;

  // Diagonal numerator |p - s|, p and s sums of two squares
  function automatic logic [NW:0] diag_num(input logic [PW-2:0] p0, input logic [PW-2:0] p1,
                                           input logic [PW-2:0] s0, input logic [PW-2:0] s1);
    logic [PW-1:0] p, s;
    logic          ng;
    logic [PW-1:0] m;
    p  = {1'b0, p0} + {1'b0, p1};
    s  = {1'b0, s0} + {1'b0, s1};
    ng = (p < s);
    m  = ng ? (s - p) : (p - s);
    return {ng, 1'b0, m};
  endfunction

  // Off-diagonal numerator 2|p1 +- p2|
  function automatic logic [NW:0] off_num(input logic signed [PW-1:0] p1,
                                          input logic signed [PW-1:0] p2, input logic sub);
    logic signed [PW:0] d;
    logic [PW:0]        ad;
    d  = sub ? ({p1[PW-1], p1} - {p2[PW-1], p2}) : ({p1[PW-1], p1} + {p2[PW-1], p2});
    ad = d[PW] ? (~d + 1'b1) : d;
    return {d[PW], ad[PW-1:0], 1'b0};
  endfunction

  assign sq_w = w_i * w_i;
  assign sq_x = x_i * x_i;
  assign sq_y = y_i * y_i;
  assign sq_z = z_i * z_i;

  assign in_ready_o = !ctl_a_q.valid || rdy_a;
  assign rdy_a      = !ctl_b_q.valid || out_ready_i;

  // Stage A control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
    end else if (in_ready_o) begin
      ctl_a_q.valid <= in_valid_i;
      ctl_a_q.degen <= (w_i == '0) && (x_i == '0) && (y_i == '0) && (z_i == '0);
    end
  end

  // Stage A payload: squares and cross products
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      ww_q <= sq_w[PW-2:0];
      xx_q <= sq_x[PW-2:0];
      yy_q <= sq_y[PW-2:0];
      zz_q <= sq_z[PW-2:0];
      xy_q <= x_i * y_i;
      wz_q <= w_i * z_i;
      xz_q <= x_i * z_i;
      wy_q <= w_i * y_i;
      yz_q <= y_i * z_i;
      wx_q <= w_i * x_i;
    end
  end

  // Form squared length and the nine numerators
  always_comb begin
    n_d = {2'b00, ww_q} + {2'b00, xx_q} + {2'b00, yy_q} + {2'b00, zz_q};
    {neg_d[qtrm_pkg::LANE_M00], a_d[qtrm_pkg::LANE_M00]} = diag_num(ww_q, xx_q, yy_q, zz_q);
    {neg_d[qtrm_pkg::LANE_M11], a_d[qtrm_pkg::LANE_M11]} = diag_num(ww_q, yy_q, xx_q, zz_q);
    {neg_d[qtrm_pkg::LANE_M22], a_d[qtrm_pkg::LANE_M22]} = diag_num(ww_q, zz_q, xx_q, yy_q);
    {neg_d[qtrm_pkg::LANE_M01], a_d[qtrm_pkg::LANE_M01]} = off_num(xy_q, wz_q, 1'b1);
    {neg_d[qtrm_pkg::LANE_M02], a_d[qtrm_pkg::LANE_M02]} = off_num(xz_q, wy_q, 1'b0);
    {neg_d[qtrm_pkg::LANE_M10], a_d[qtrm_pkg::LANE_M10]} = off_num(xy_q, wz_q, 1'b0);
    {neg_d[qtrm_pkg::LANE_M12], a_d[qtrm_pkg::LANE_M12]} = off_num(yz_q, wx_q, 1'b1);
    {neg_d[qtrm_pkg::LANE_M20], a_d[qtrm_pkg::LANE_M20]} = off_num(xz_q, wy_q, 1'b1);
    {neg_d[qtrm_pkg::LANE_M21], a_d[qtrm_pkg::LANE_M21]} = off_num(yz_q, wx_q, 1'b0);
  end

  // Stage B control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_b_q <= '0;
    end else if (rdy_a) begin
      ctl_b_q <= ctl_a_q;
    end
  end

  // Stage B payload
  always_ff @(posedge clk_i) begin
    if (rdy_a && ctl_a_q.valid) begin
      n_q   <= n_d;
      a_q   <= a_d;
      neg_q <= neg_d;
    end
  end

  assign out_ctl_o = ctl_b_q;
  assign out_n_o   = n_q;
  assign out_a_o   = a_q;
  assign out_neg_o = neg_q;

endmodule

FILE: design/qtrm_div_stage.sv
// ---------------------------------------------------------------------------
// qtrm_div_stage
// One restoring division step for all nine lanes: one quotient bit per stage.
// ---------------------------------------------------------------------------
module qtrm_div_stage #(
  parameter int W     = 16,
  parameter bit FIRST = 1'b0
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  qtrm_pkg::ctl_t                                in_ctl_i,
  output logic                                          in_ready_o,
  input  logic [2*W:0]                                  in_n_i,
  input  logic [qtrm_pkg::NUM_LANES-1:0][2*W:0]         in_r_i,
  input  logic [qtrm_pkg::NUM_LANES-1:0][W-1:0]         in_q_i,
  input  logic [qtrm_pkg::NUM_LANES-1:0]                in_neg_i,
  input  logic                                          out_ready_i,
  output qtrm_pkg::ctl_t                                out_ctl_o,
  output logic [2*W:0]                                  out_n_o,
  output logic [qtrm_pkg::NUM_LANES-1:0][2*W:0]         out_r_o,
  output logic [qtrm_pkg::NUM_LANES-1:0][W-1:0]         out_q_o,
  output logic [qtrm_pkg::NUM_LANES-1:0]                out_neg_o
);
  localparam int NW = 2 * W + 1;

  qtrm_pkg::ctl_t                          ctl_q;
  logic [NW-1:0]                           n_q;
  logic [qtrm_pkg::NUM_LANES-1:0][NW-1:0]  r_q, r_d;
  logic [qtrm_pkg::NUM_LANES-1:0][W-1:0]   q_q, q_d;
  logic [qtrm_pkg::NUM_LANES-1:0]          neg_q;
  logic [NW:0]                             t;

  assign in_ready_o = !ctl_q.valid || out_ready_i;

  // Trial subtract per lane, shift in the quotient bit
  always_comb begin
    t = '0;
    for (int l = 0; l < qtrm_pkg::NUM_LANES; l++) begin
      t = FIRST ? {1'b0, in_r_i[l]} : {in_r_i[l], 1'b0};
      if (t >= {1'b0, in_n_i}) begin
        r_d[l] = NW'(t - {1'b0, in_n_i});
        q_d[l] = {in_q_i[l][W-2:0], 1'b1};
      end else begin
        r_d[l] = t[NW-1:0];
        q_d[l] = {in_q_i[l][W-2:0], 1'b0};
      end
    end
  end

  // Hold control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (in_ready_o) begin
      ctl_q <= in_ctl_i;
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_ctl_i.valid) begin
      n_q   <= in_n_i;
      r_q   <= r_d;
      q_q   <= q_d;
      neg_q <= in_neg_i;
    end
  end

  assign out_ctl_o = ctl_q;
  assign out_n_o   = n_q;
  assign out_r_o   = r_q;
  assign out_q_o   = q_q;
  assign out_neg_o = neg_q;

endmodule

FILE: design/qtrm_pack.sv
// ---------------------------------------------------------------------------
// qtrm_pack
// Output stage: round half up, saturate, apply sign, identity on zero input.
// ---------------------------------------------------------------------------
module qtrm_pack #(
  parameter int W = 16
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  qtrm_pkg::ctl_t                               in_ctl_i,
  output logic                                         in_ready_o,
  input  logic [qtrm_pkg::NUM_LANES-1:0][W-1:0]        in_q_i,
  input  logic [qtrm_pkg::NUM_LANES-1:0]               in_neg_i,
  input  logic                                         out_stall_i,
  output qtrm_pkg::ctl_t                               out_ctl_o,
  output logic [qtrm_pkg::NUM_LANES-1:0][W-1:0]        out_m_o
);
  localparam int F = W - 2;
  localparam logic [W-1:0] ONE = W'(1) << F;

  qtrm_pkg::ctl_t                        ctl_q;
  logic [qtrm_pkg::NUM_LANES-1:0][W-1:0] m_q, m_d;
  logic [W:0]                            rnd;
  logic [W-1:0]                          mag;

  assign in_ready_o = !ctl_q.valid || !out_stall_i;

  // Round the extra quotient bit away, clamp to one, negate
  always_comb begin
    rnd = '0;
    mag = '0;
    for (int l = 0; l < qtrm_pkg::NUM_LANES; l++) begin
      rnd = ({1'b0, in_q_i[l]} + 1'b1) >> 1;
      mag = (rnd > {1'b0, ONE}) ? ONE : rnd[W-1:0];
      if (in_ctl_i.degen) begin
        m_d[l] = ((l == qtrm_pkg::LANE_M00) || (l == qtrm_pkg::LANE_M11) ||
                  (l == qtrm_pkg::LANE_M22)) ? ONE : '0;
      end else begin
        m_d[l] = in_neg_i[l] ? (~mag + 1'b1) : mag;
      end
    end
  end

  // Hold control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else if (in_ready_o) begin
      ctl_q <= in_ctl_i;
    end
  end

  // Output register
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_ctl_i.valid) begin
      m_q <= m_d;
    end
  end

  assign out_ctl_o = ctl_q;
  assign out_m_o   = m_q;

endmodule

FILE: design/quaternion_to_rotation_matrix_top.sv
// Pipeline from accepted quaternion to valid matrix: two front stages, DATA_WIDTH one-bit
// restoring division stages, one output stage.
// Throughput: one transaction per cycle; every stage advances when its successor frees.
// Reset: rst_ni clears all stage valid bits asynchronously; no payload is reset.
// ---------------------------------------------------------------------------
// quaternion_to_rotation_matrix_top
// Normalises a Q2.x quaternion and gives its 3x3 rotation matrix in Q2.x.
// ---------------------------------------------------------------------------
`include "quaternion_to_rotation_matrix_top_macros.svh"

module quaternion_to_rotation_matrix_top #(
  parameter int DATA_WIDTH = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic signed [DATA_WIDTH-1:0] quat_w_i,
  input  logic signed [DATA_WIDTH-1:0] quat_x_i,
  input  logic signed [DATA_WIDTH-1:0] quat_y_i,
  input  logic signed [DATA_WIDTH-1:0] quat_z_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic signed [DATA_WIDTH-1:0] m00_o,
  output logic signed [DATA_WIDTH-1:0] m01_o,
  output logic signed [DATA_WIDTH-1:0] m02_o,
  output logic signed [DATA_WIDTH-1:0] m10_o,
  output logic signed [DATA_WIDTH-1:0] m11_o,
  output logic signed [DATA_WIDTH-1:0] m12_o,
  output logic signed [DATA_WIDTH-1:0] m20_o,
  output logic signed [DATA_WIDTH-1:0] m21_o,
  output logic signed [DATA_WIDTH-1:0] m22_o,
  output logic                         degenerate_o
);
  localparam int W  = DATA_WIDTH;
  localparam int NW = 2 * W + 1;
  localparam int NS = W;            // division stages: integer bit plus W-1 fraction bits
  localparam logic signed [W-1:0] ONE  = W'(1) << (W - 2);
  localparam logic signed [W-1:0] MONE = -ONE;

  logic                                            front_ready;
  qtrm_pkg::ctl_t                                  ctl_s [NS+1];
  logic [NW-1:0]                                   n_s   [NS+1];
  logic [qtrm_pkg::NUM_LANES-1:0][NW-1:0]          r_s   [NS+1];
  logic [qtrm_pkg::NUM_LANES-1:0][W-1:0]           q_s   [NS+1];
  logic [qtrm_pkg::NUM_LANES-1:0]                  neg_s [NS+1];
  logic                                            rdy_s [NS+1];
  qtrm_pkg::ctl_t                                  out_ctl;
  logic [qtrm_pkg::NUM_LANES-1:0][W-1:0]           m;

  // Squares, products and numerators
  qtrm_front #(.W(W)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (front_ready),
    .w_i         (quat_w_i),
    .x_i         (quat_x_i),
    .y_i         (quat_y_i),
    .z_i         (quat_z_i),
    .out_ready_i (rdy_s[0]),
    .out_ctl_o   (ctl_s[0]),
    .out_n_o     (n_s[0]),
    .out_a_o     (r_s[0]),
    .out_neg_o   (neg_s[0])
  );

  assign in_stall_o = !front_ready;
  assign q_s[0]     = '0;

  // Division chain, one quotient bit per stage
  for (genvar k = 0; k < NS; k++) begin : g_div
    qtrm_div_stage #(.W(W), .FIRST(k == 0)) u_div (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .in_ctl_i    (ctl_s[k]),
      .in_ready_o  (rdy_s[k]),
      .in_n_i      (n_s[k]),
      .in_r_i      (r_s[k]),
      .in_q_i      (q_s[k]),
      .in_neg_i    (neg_s[k]),
      .out_ready_i (rdy_s[k+1]),
      .out_ctl_o   (ctl_s[k+1]),
      .out_n_o     (n_s[k+1]),
      .out_r_o     (r_s[k+1]),
      .out_q_o     (q_s[k+1]),
      .out_neg_o   (neg_s[k+1])
    );
  end

  // Round, saturate and register the result
  qtrm_pack #(.W(W)) u_pack (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_ctl_i    (ctl_s[NS]),
    .in_ready_o  (rdy_s[NS]),
    .in_q_i      (q_s[NS]),
    .in_neg_i    (neg_s[NS]),
    .out_stall_i (out_stall_i),
    .out_ctl_o   (out_ctl),
    .out_m_o     (m)
  );

  assign out_valid_o  = out_ctl.valid;
  assign degenerate_o = out_ctl.degen;
  assign m00_o = m[qtrm_pkg::LANE_M00];
  assign m01_o = m[qtrm_pkg::LANE_M01];
  assign m02_o = m[qtrm_pkg::LANE_M02];
  assign m10_o = m[qtrm_pkg::LANE_M10];
  assign m11_o = m[qtrm_pkg::LANE_M11];
  assign m12_o = m[qtrm_pkg::LANE_M12];
  assign m20_o = m[qtrm_pkg::LANE_M20];
  assign m21_o = m[qtrm_pkg::LANE_M21];
  assign m22_o = m[qtrm_pkg::LANE_M22];

  // A zero quaternion gives the identity
  `QTRM_ASSERT_IMP(a_degen_identity, clk_i, rst_ni, out_valid_o && degenerate_o,
                   m00_o == ONE && m11_o == ONE && m22_o == ONE && m01_o == '0 && m12_o == '0)
  // Entries m00 and m12 stay within plus or minus one
  `QTRM_ASSERT_IMP(a_range, clk_i, rst_ni, out_valid_o,
                   m00_o <= ONE && m00_o >= MONE && m12_o <= ONE && m12_o >= MONE)
  // An empty output stage never holds off the input
  `QTRM_ASSERT_IMP(a_no_false_stall, clk_i, rst_ni, !out_valid_o, !in_stall_o)

endmodule
